FILE: src/sfir_pkg.sv
// sfir_pkg: shared types, widths and reset coefficients for the symmetric
// 13-tap fir filter. No dependencies; used by the interfaces and every module.
`default_nettype none

package sfir_pkg;

    // filter geometry
    localparam int ORDER     = 12;
    localparam int NUM_COEF  = 7;
    localparam int CENTER    = ORDER / 2;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int FRAC_BITS = 23;

    // datapath widths: pre-add grows one bit, products and sum of seven
    localparam int PRE_W  = SAMPLE_W + 1;
    localparam int PROD_W = PRE_W + COEF_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int QUO_W  = ACC_W - FRAC_BITS;

    // configuration port
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;
    localparam logic [REG_IDX_W-1:0] REG_COEF_LAST = REG_IDX_W'(NUM_COEF - 1);

    // pipeline depth of the datapath
    localparam int NUM_STG = 6;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PRE_W-1:0]    t_pre;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [QUO_W-1:0]    t_quo;

    typedef t_coef [NUM_COEF-1:0] t_coef_vec;
    typedef t_pre  [NUM_COEF-1:0] t_pre_vec;

    localparam t_coef_vec COEF_RESET = '{
        t_coef'(3893229),  t_coef'(-67), t_coef'(-2642085), t_coef'(-57),
        t_coef'(459328),   t_coef'(-37), t_coef'(549770)
    };

endpackage

`default_nettype wire

FILE: src/sfir_if.sv
// sfir_if: valid/ready stream interfaces for the sample input and the result
// output channels. Depends on sfir_pkg for the sample type.
`default_nettype none

interface sfir_in_if;
    logic               valid;
    logic               ready;
    sfir_pkg::t_sample  sample_in;
    logic               frame_last;

    modport source (output valid, output sample_in, output frame_last, input ready);
    modport sink   (input valid, input sample_in, input frame_last, output ready);
endinterface

interface sfir_out_if;
    logic               valid;
    logic               ready;
    sfir_pkg::t_sample  sample_out;
    logic               clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

FILE: src/sfir_datapath.sv
// sfir_datapath: pipelined multiply, adder tree, rounding and saturation of
// the pre-added tap pairs. Depends on sfir_pkg.
`default_nettype none

module sfir_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire sfir_pkg::t_pre_vec  i_pre,
    input  wire sfir_pkg::t_coef_vec i_coef,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output sfir_pkg::t_sample        o_sample,
    output logic                     o_clipped
);

    logic [sfir_pkg::NUM_STG-1:0] r_vld;
    logic [sfir_pkg::NUM_STG-1:0] w_en;

    sfir_pkg::t_pre_vec              r_pre;
    sfir_pkg::t_prod [sfir_pkg::NUM_COEF-1:0] r_prod;
    sfir_pkg::t_acc  [3:0]           r_sum4;
    sfir_pkg::t_acc  [1:0]           r_sum2;
    sfir_pkg::t_acc                  r_sum;
    sfir_pkg::t_sample               r_out;
    logic                            r_clip;

    sfir_pkg::t_acc  w_round;
    sfir_pkg::t_quo  w_quo;
    sfir_pkg::t_sample n_out;
    logic            n_clip;

    // per-stage advance, bubbles collapse so a stalled output still lets input in
    always_comb begin
        w_en[sfir_pkg::NUM_STG-1] = !r_vld[sfir_pkg::NUM_STG-1] || i_ready;
        for (int k = sfir_pkg::NUM_STG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < sfir_pkg::NUM_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // round half up at the binary point, then clamp to 16 bits
    always_comb begin
        w_round = r_sum + sfir_pkg::t_acc'(1 <<< (sfir_pkg::FRAC_BITS - 1));
        w_quo   = w_round[sfir_pkg::ACC_W-1:sfir_pkg::FRAC_BITS];
        n_out   = w_quo[sfir_pkg::SAMPLE_W-1:0];
        n_clip  = 1'b0;
        if (!w_quo[sfir_pkg::QUO_W-1] && (|w_quo[sfir_pkg::QUO_W-2:sfir_pkg::SAMPLE_W-1])) begin
            n_out  = {1'b0, {(sfir_pkg::SAMPLE_W-1){1'b1}}};
            n_clip = 1'b1;
        end else if (w_quo[sfir_pkg::QUO_W-1]
                     && !(&w_quo[sfir_pkg::QUO_W-2:sfir_pkg::SAMPLE_W-1])) begin
            n_out  = {1'b1, {(sfir_pkg::SAMPLE_W-1){1'b0}}};
            n_clip = 1'b1;
        end
    end

    // payload stages: pre-add, products, adder tree, output
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pre <= i_pre;
        end
        if (w_en[1]) begin
            for (int m = 0; m < sfir_pkg::NUM_COEF; m++) begin
                r_prod[m] <= sfir_pkg::t_prod'(r_pre[m]) * sfir_pkg::t_prod'(i_coef[m]);
            end
        end
        if (w_en[2]) begin
            r_sum4[0] <= sfir_pkg::t_acc'(r_prod[0]) + sfir_pkg::t_acc'(r_prod[1]);
            r_sum4[1] <= sfir_pkg::t_acc'(r_prod[2]) + sfir_pkg::t_acc'(r_prod[3]);
            r_sum4[2] <= sfir_pkg::t_acc'(r_prod[4]) + sfir_pkg::t_acc'(r_prod[5]);
            r_sum4[3] <= sfir_pkg::t_acc'(r_prod[6]);
        end
        if (w_en[3]) begin
            r_sum2[0] <= r_sum4[0] + r_sum4[1];
            r_sum2[1] <= r_sum4[2] + r_sum4[3];
        end
        if (w_en[4]) begin
            r_sum <= r_sum2[0] + r_sum2[1];
        end
        if (w_en[5]) begin
            r_out  <= n_out;
            r_clip <= n_clip;
        end
    end

    assign o_valid   = r_vld[sfir_pkg::NUM_STG-1];
    assign o_sample  = r_out;
    assign o_clipped = r_clip;

endmodule

`default_nettype wire

FILE: src/symmetric_fir_filter_13tap_core.sv
// symmetric_fir_filter_13tap_core: top level with coefficient registers,
// delay line and pair pre-add. Depends on sfir_pkg, sfir_if, sfir_datapath.
// Throughput: one sample per cycle while out_ch.ready holds; a six-stage pipeline
// (pre-add, multiply, three adder levels, round/saturate) with stall-collapsing stages.
// Reset (synchronous, active low): delay line zero, coefficients to defaults,
// pipeline empty.
`default_nettype none

module symmetric_fir_filter_13tap_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    sfir_in_if.sink                              in_ch,
    sfir_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfir_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [sfir_pkg::DATA_W-1:0]     pwdata,
    output logic      [sfir_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready
);

    sfir_pkg::t_coef_vec r_coef;
    sfir_pkg::t_sample [sfir_pkg::ORDER-1:0] r_hist;
    sfir_pkg::t_pre_vec  w_pre;
    sfir_pkg::t_sample   w_lo;
    sfir_pkg::t_sample   w_hi;
    sfir_pkg::t_coef     w_rd_coef;
    logic [sfir_pkg::REG_IDX_W-1:0] w_idx;
    logic                w_wr;
    logic                w_in_rdy;
    logic                w_accept;

    assign pready = 1'b1;
    assign w_idx  = paddr[sfir_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= sfir_pkg::COEF_RESET;
        end else if (w_wr && (w_idx <= sfir_pkg::REG_COEF_LAST)) begin
            r_coef[w_idx] <= pwdata[sfir_pkg::COEF_W-1:0];
        end
    end

    // register readback, sign extended
    always_comb begin
        w_rd_coef = '0;
        if (w_idx <= sfir_pkg::REG_COEF_LAST) begin
            w_rd_coef = r_coef[w_idx];
        end
        prdata = {{(sfir_pkg::DATA_W-sfir_pkg::COEF_W){w_rd_coef[sfir_pkg::COEF_W-1]}},
                  w_rd_coef};
    end

    assign w_accept   = in_ch.valid && w_in_rdy;
    assign in_ch.ready = w_in_rdy;

    // delay line: shift on every transfer; the last sample of a frame clears it instead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (w_accept) begin
            if (in_ch.frame_last) begin
                r_hist <= '0;
            end else begin
                for (int k = sfir_pkg::ORDER - 1; k > 0; k--) begin
                    r_hist[k] <= r_hist[k-1];
                end
                r_hist[0] <= in_ch.sample_in;
            end
        end
    end

    // pre-add the symmetric tap pairs; the centre tap stands alone
    always_comb begin
        w_lo = '0;
        w_hi = '0;
        for (int m = 0; m < sfir_pkg::NUM_COEF; m++) begin
            w_lo = (m == 0) ? in_ch.sample_in : r_hist[(m == 0) ? 0 : m - 1];
            w_hi = r_hist[sfir_pkg::ORDER - 1 - m];
            if (m == sfir_pkg::CENTER) begin
                w_pre[m] = sfir_pkg::t_pre'(w_lo);
            end else begin
                w_pre[m] = sfir_pkg::t_pre'(w_lo) + sfir_pkg::t_pre'(w_hi);
            end
        end
    end

    sfir_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_ch.valid),
        .o_ready   (w_in_rdy),
        .i_pre     (w_pre),
        .i_coef    (r_coef),
        .o_valid   (out_ch.valid),
        .i_ready   (out_ch.ready),
        .o_sample  (out_ch.sample_out),
        .o_clipped (out_ch.clipped)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_symmetric_fir_filter_13tap_core.sv
// tb_symmetric_fir_filter_13tap_core: self-checking bench for the symmetric 13-tap fir core,
// with directed and random sample streams, bursty input, stalling output and coefficient sweeps.
// Depends on sfir_pkg, sfir_if and symmetric_fir_filter_13tap_core from the rtl.

module tb_symmetric_fir_filter_13tap_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sfir_pkg::*;

    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 150;
    localparam int REG_OUT_OF_RANGE = NUM_COEF;

    typedef struct packed {
        t_sample sample;
        logic    clipped;
    } t_filtered;

    typedef struct {
        t_sample sample;
        logic    last;
        logic    pinned;
        t_sample want;
        logic    want_clip;
    } t_stim_row;

    localparam t_sample PMAX = 16'sh7FFF;
    localparam t_sample NMAX = -16'sh8000;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    sfir_in_if  in_bus ();
    sfir_out_if out_bus ();

    symmetric_fir_filter_13tap_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the filter: coefficients, delay line and pending outputs
    t_coef     coef_q [NUM_COEF];
    t_sample   delay_q [ORDER];
    t_filtered filtered_q [$];

    int mismatch_cnt = 0;
    int results_seen = 0;
    int burst_left   = 0;

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
    endtask

    // one filter step: dot product, round half up from q1.23, saturate, then shift history
    function automatic t_filtered filter_sample(input t_sample x, input logic last);
        longint acc;
        longint y;
        int m;
        t_filtered r;
        acc = longint'(coef_q[0]) * longint'(x);
        for (int k = 1; k <= ORDER; k++) begin
            m = (k < ORDER - k) ? k : ORDER - k;
            if (m < NUM_COEF)
                acc += longint'(coef_q[m]) * longint'(delay_q[k-1]);
        end
        y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r.clipped = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.clipped = 1'b1;
        end
        if (y < -32768) begin
            y = -32768;
            r.clipped = 1'b1;
        end
        r.sample = t_sample'(y);
        if (last) begin
            foreach (delay_q[i]) delay_q[i] = '0;
        end else begin
            for (int k = ORDER - 1; k > 0; k--) delay_q[k] = delay_q[k-1];
            delay_q[0] = x;
        end
        return r;
    endfunction

    // register write over the apb port, setup then access; called at a falling edge,
    // returns at a falling edge with the bus idle
    task automatic write_coef(input int idx, input t_coef val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= {8'($urandom()), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!(psel && penable && pwrite && pready));
        if (idx < NUM_COEF) coef_q[idx] = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // offer one sample and hold it until the transfer; called at a falling edge
    task automatic push_sample(input t_sample x, input logic last,
                               input logic pinned, input t_filtered pinned_res);
        t_filtered r;
        in_bus.valid      <= 1'b1;
        in_bus.sample_in  <= x;
        in_bus.frame_last <= last;
        do @(posedge i_clk); while (!(in_bus.valid && in_bus.ready));
        r = filter_sample(x, last);
        filtered_q.push_back(pinned ? pinned_res : r);
        @(negedge i_clk);
    endtask

    // bursts of random length with random gaps, some stretches gap-free
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic stop_sender();
        if (in_bus.valid) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // wait for every pending output, then let the pipeline run empty
    task automatic drain();
        while (filtered_q.size() != 0) @(negedge i_clk);
        repeat (NUM_STG + 2) @(negedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 9))
            5:       return PMAX;
            6:       return NMAX;
            7, 8:    return t_sample'(int'($urandom_range(0, 8)) - 4);
            default: return t_sample'($urandom());
        endcase
    endfunction

    // output check against the oldest pending result
    always @(posedge i_clk) begin : check_output
        t_filtered want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            results_seen++;
            if (filtered_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer, sample_out %0d",
                                        out_bus.sample_out));
            end else begin
                want = filtered_q.pop_front();
                if (out_bus.sample_out !== want.sample)
                    flag_mismatch($sformatf("sample_out got %0d want %0d",
                                            out_bus.sample_out, want.sample));
                if (out_bus.clipped !== want.clipped)
                    flag_mismatch($sformatf("clipped got %0b want %0b",
                                            out_bus.clipped, want.clipped));
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin : watchdog
        int idle_cnt;
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output stall pattern, with one long hold-off so the pipeline backs up
    initial begin : drive_ready
        int run_left;
        int mode;
        int hold_left;
        int tick;
        bit hold_done;
        run_left  = 0;
        mode      = 0;
        hold_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (run_left == 0) begin
                mode     = $urandom_range(0, 3);
                run_left = $urandom_range(8, 64);
            end
            run_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       out_bus.ready <= 1'b1;
                    1:       out_bus.ready <= 1'($urandom_range(0, 1));
                    2:       out_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: out_bus.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // main sequence
    initial begin : run_test
        t_stim_row rows [$];
        t_coef     phase_coef [NUM_COEF];

        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_bus.valid      = 1'b0;
        in_bus.sample_in  = '0;
        in_bus.frame_last = 1'b0;
        foreach (coef_q[i]) coef_q[i] = COEF_RESET[i];
        foreach (delay_q[i]) delay_q[i] = '0;

        // directed stimulus: zero history, worst-case positive pattern, frame ends
        rows = '{
            '{16'sd0,    1'b0, 1'b1, 16'sd0, 1'b0},
            '{PMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{PMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{PMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{PMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{PMAX,      1'b0, 1'b1, PMAX,   1'b1},
            '{16'sd1234, 1'b1, 1'b0, 16'sd0, 1'b0},
            '{PMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b0, 1'b0, 16'sd0, 1'b0},
            '{16'sd1,    1'b0, 1'b0, 16'sd0, 1'b0},
            '{-16'sd1,   1'b0, 1'b0, 16'sd0, 1'b0},
            '{NMAX,      1'b1, 1'b0, 16'sd0, 1'b0},
            '{16'sd0,    1'b1, 1'b1, 16'sd0, 1'b0},
            '{16'sd0,    1'b0, 1'b1, 16'sd0, 1'b0}
        };

        // reset
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // a write past the last register must leave the defaults alone
        write_coef(REG_OUT_OF_RANGE, 24'sh7FFFFF);

        foreach (rows[i]) begin
            push_sample(rows[i].sample, rows[i].last, rows[i].pinned,
                        '{rows[i].want, rows[i].want_clip});
            pace_sender();
        end

        // random phases with per-phase coefficient sets; the first and last use the defaults
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            stop_sender();
            drain();
            foreach (phase_coef[i]) begin
                case (ph)
                    1:       phase_coef[i] = 24'sh7FFFFF;
                    2:       phase_coef[i] = -24'sh800000;
                    3:       phase_coef[i] = (i % 2 == 0) ? 24'sh7FFFFF : -24'sh800000;
                    4:       phase_coef[i] = t_coef'($urandom());
                    5:       phase_coef[i] = (i == 0) ? 24'sh400000 : 24'sh0;
                    6:       phase_coef[i] = t_coef'(int'($urandom_range(0, 511)) - 256);
                    default: phase_coef[i] = COEF_RESET[i];
                endcase
            end
            if (ph != 0) begin
                foreach (phase_coef[i]) write_coef(i, phase_coef[i]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_sample(rand_sample(), ($urandom_range(0, 19) == 0), 1'b0, '0);
                pace_sender();
            end
        end

        // wind down
        stop_sender();
        drain();
        repeat (NUM_STG + 4) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
